/* src/sbl_pkg.sv */
`default_nettype none

package sbl_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int GRAD_BITS   = 11;
    localparam int ROW_BITS    = 12;
    localparam int LINE_W_BITS = 11;
    localparam int MIN_WIDTH   = 3;

    localparam logic [LINE_W_BITS-1:0] LINE_W_RESET = 11'd640;

    // one column of the 3x3 window
    typedef struct packed {
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] bot;
    } col_t;

endpackage

`default_nettype wire

/* src/sobel_gradient_3x3.sv */
`default_nettype none

// Streaming 3x3 Sobel gradient. Grey pixels enter in raster order, one word
// per clock when not stalled; each accepted pixel at row >= 2 and column >= 2
// gives one word, via stage 2 and the output register, with both signed
// gradients (grad_a: rows 1,2,1 over -1,-2,-1; grad_b: columns 1,2,1 left
// over -1,-2,-1 right) and the coordinates of the window centre. Border
// positions produce no word. The two-stage pipe is set by the registered
// read of the line-store RAMs; the window itself is a chain of column cells
// that slides once per pixel. frame_start restarts row and column at zero.
// line_width is clamped to 3..MAX_WIDTH and must be written while the block
// is idle. A fill count stands in for clearing the line stores, so there is
// no clearing pass after reset: the block accepts pixels at once.
module sobel_gradient_3x3 #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [sbl_pkg::LINE_W_BITS-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [sbl_pkg::PIXEL_BITS-1:0]    pixel,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [sbl_pkg::GRAD_BITS-1:0]   grad_a,
    output logic signed [sbl_pkg::GRAD_BITS-1:0]   grad_b,
    output logic [sbl_pkg::ROW_BITS-1:0]           centre_row,
    output logic [COL_BITS-1:0]                    centre_col
);

    import sbl_pkg::*;

    localparam int WB = (COL_BITS + 1 > LINE_W_BITS) ? COL_BITS + 1 : LINE_W_BITS;
    localparam int HB = COL_BITS + 1;
    localparam int SUM_BITS = PIXEL_BITS + 2;

    // configuration
    logic [LINE_W_BITS-1:0] line_width_reg;
    logic [WB-1:0]          lw_ext;
    logic [WB-1:0]          eff_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_W_RESET;
        end
        else if (cfg_write)
        begin
            line_width_reg <= cfg_data;
        end
    end

    assign lw_ext = WB'(line_width_reg);
    assign eff_w  = (lw_ext < WB'(MIN_WIDTH)) ? WB'(MIN_WIDTH) :
                    ((lw_ext > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : lw_ext);

    // stage 1: position and line-store read
    logic                accept;
    logic                s2_valid_reg;
    logic                s2_adv;
    logic                out_valid_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_start;
    logic [ROW_BITS-1:0] row_start;
    logic                wrap_pre;
    logic [COL_BITS-1:0] cur_col;
    logic [ROW_BITS-1:0] cur_row;
    logic [WB-1:0]       col_inc;
    logic                wrap_post;
    logic [COL_BITS-1:0] col_next;
    logic [ROW_BITS-1:0] row_next;
    logic [HB-1:0]       fill_reg;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s2_valid_reg || s2_adv;
    assign accept   = in_valid && in_ready;

    assign col_start = frame_start ? '0 : col_reg;
    assign row_start = frame_start ? '0 : row_reg;
    assign wrap_pre  = WB'(col_start) >= eff_w;
    assign cur_col   = wrap_pre ? '0 : col_start;
    assign cur_row   = wrap_pre ? row_start + 1'b1 : row_start;
    assign col_inc   = WB'(cur_col) + 1'b1;
    assign wrap_post = col_inc >= eff_w;
    assign col_next  = wrap_post ? '0 : col_inc[COL_BITS-1:0];
    assign row_next  = wrap_post ? cur_row + 1'b1 : cur_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 2 registers
    logic [PIXEL_BITS-1:0] s2_pix_reg;
    logic [COL_BITS-1:0]   s2_col_reg;
    logic [ROW_BITS-1:0]   s2_row_reg;
    logic                  s2_emit_reg;
    logic                  s2_live_reg;
    logic                  s2_fwd_reg;
    logic [PIXEL_BITS-1:0] s2_fwd_top_reg;
    logic [PIXEL_BITS-1:0] s2_fwd_mid_reg;
    logic [PIXEL_BITS-1:0] upper_rdata;
    logic [PIXEL_BITS-1:0] lower_rdata;
    col_t                  win0;
    col_t                  win1;
    col_t                  win2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_pix_reg     <= pixel;
            s2_col_reg     <= cur_col;
            s2_row_reg     <= cur_row;
            s2_emit_reg    <= (cur_row >= ROW_BITS'(2)) && (cur_col >= COL_BITS'(2));
            s2_live_reg    <= HB'(cur_col) < fill_reg;
            // the word ahead writes this same entry in this cycle
            s2_fwd_reg     <= s2_adv && (s2_col_reg == cur_col);
            s2_fwd_top_reg <= win0.mid;
            s2_fwd_mid_reg <= win0.bot;
        end
    end

    assign win0.top = s2_fwd_reg ? s2_fwd_top_reg :
                      (s2_live_reg ? upper_rdata : '0);
    assign win0.mid = s2_fwd_reg ? s2_fwd_mid_reg :
                      (s2_live_reg ? lower_rdata : '0);
    assign win0.bot = s2_pix_reg;

    // entries ever written always form a prefix of the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (s2_adv && (HB'(s2_col_reg) == fill_reg))
        begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    sbl_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk   (clk),
        .we    (s2_adv),
        .waddr (s2_col_reg),
        .wdata (win0.mid),
        .re    (accept),
        .raddr (cur_col),
        .rdata (upper_rdata)
    );

    sbl_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_lower (
        .clk   (clk),
        .we    (s2_adv),
        .waddr (s2_col_reg),
        .wdata (win0.bot),
        .re    (accept),
        .raddr (cur_col),
        .rdata (lower_rdata)
    );

    sbl_col_cell u_cell_1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s2_adv),
        .col_in  (win0),
        .col_out (win1)
    );

    sbl_col_cell u_cell_2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s2_adv),
        .col_in  (win1),
        .col_out (win2)
    );

    // kernel sums, left column is win2, right column is win0
    logic [SUM_BITS-1:0]         sum_top;
    logic [SUM_BITS-1:0]         sum_bot;
    logic [SUM_BITS-1:0]         sum_left;
    logic [SUM_BITS-1:0]         sum_right;
    logic signed [GRAD_BITS-1:0] ga;
    logic signed [GRAD_BITS-1:0] gb;

    assign sum_top   = SUM_BITS'(win2.top) + {1'b0, win1.top, 1'b0} + SUM_BITS'(win0.top);
    assign sum_bot   = SUM_BITS'(win2.bot) + {1'b0, win1.bot, 1'b0} + SUM_BITS'(win0.bot);
    assign sum_left  = SUM_BITS'(win2.top) + {1'b0, win2.mid, 1'b0} + SUM_BITS'(win2.bot);
    assign sum_right = SUM_BITS'(win0.top) + {1'b0, win0.mid, 1'b0} + SUM_BITS'(win0.bot);
    assign ga = signed'({1'b0, sum_top})  - signed'({1'b0, sum_bot});
    assign gb = signed'({1'b0, sum_left}) - signed'({1'b0, sum_right});

    // output register
    logic signed [GRAD_BITS-1:0] grad_a_reg;
    logic signed [GRAD_BITS-1:0] grad_b_reg;
    logic [ROW_BITS-1:0]         centre_row_reg;
    logic [COL_BITS-1:0]         centre_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= s2_emit_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_emit_reg)
        begin
            grad_a_reg     <= ga;
            grad_b_reg     <= gb;
            centre_row_reg <= s2_row_reg - 1'b1;
            centre_col_reg <= s2_col_reg - 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign grad_a     = grad_a_reg;
    assign grad_b     = grad_b_reg;
    assign centre_row = centre_row_reg;
    assign centre_col = centre_col_reg;

`ifndef SYNTHESIS
    a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |-> (HB'(s2_col_reg) <= fill_reg))
        else $error("line store write skips past fill count");

    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (centre_row != '0) && (centre_col != '0))
        else $error("result centre on image border");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s2_valid_reg)
        else $error("accepted word lost before stage 2");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipe is stalled");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HB'(MAX_WIDTH))
        else $error("fill count beyond store depth");
`endif

endmodule

`default_nettype wire

/* src/sbl_ram.sv */
`default_nettype none

module sbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/sbl_col_cell.sv */
`default_nettype none

module sbl_col_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire sbl_pkg::col_t col_in,
    output sbl_pkg::col_t      col_out
);

    import sbl_pkg::*;

    col_t col_reg;

    // takes the neighbor column each time the window slides
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbl_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_BITS     = 10;
    localparam int PIPE_DRAIN   = 8;
    localparam int STALL_LIMIT  = 500;
    localparam int RANDOM_WORDS = 300;
    localparam int MODE_SPAN    = 64;

    // idle patterns, switched every MODE_SPAN words
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

    typedef struct {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
        int                    gap;
    } pixel_word_t;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_a;
        logic signed [GRAD_BITS-1:0] grad_b;
        logic [ROW_BITS-1:0]         centre_row;
        logic [COL_BITS-1:0]         centre_col;
    } grad_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [LINE_W_BITS-1:0]       cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [PIXEL_BITS-1:0]        pixel = '0;
    logic                         frame_start = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [GRAD_BITS-1:0]  grad_a;
    logic signed [GRAD_BITS-1:0]  grad_b;
    logic [ROW_BITS-1:0]          centre_row;
    logic [COL_BITS-1:0]          centre_col;

    pixel_word_t pixel_queue[$];
    grad_word_t  expected_grads[$];

    int words_queued   = 0;
    int words_accepted = 0;
    int error_count    = 0;
    int in_hold        = 0;
    int out_hold       = 0;
    int out_count      = 0;
    int stall_cycles   = 0;
    idle_mode_t in_mode  = IDLE_NONE;
    idle_mode_t out_mode = IDLE_FULL;

    // shadow of the block state
    logic [PIXEL_BITS-1:0]  upper_line [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]  lower_line [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]  win_regs [6];
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;
    logic [LINE_W_BITS-1:0] line_width_reg = LINE_W_RESET;

    sobel_gradient_3x3 #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel(pixel),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .grad_a(grad_a),
        .grad_b(grad_b),
        .centre_row(centre_row),
        .centre_col(centre_col)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_gap(idle_mode_t mode);
        if (mode == IDLE_FULL)
            return $urandom_range(0, 16);
        if (mode == IDLE_SPARSE && $urandom_range(0, 7) == 0)
            return $urandom_range(1, 16);
        return 0;
    endfunction

    function automatic idle_mode_t draw_mode();
        return idle_mode_t'($urandom_range(0, 2));
    endfunction

    function automatic int unsigned eff_width(logic [LINE_W_BITS-1:0] w_reg);
        int unsigned w;
        w = w_reg;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic void step_row();
        col_pos = 0;
        row_pos = (row_pos + 1) & 32'hFFF;
    endfunction

    function automatic void predict_gradients(logic [PIXEL_BITS-1:0] pix, logic fs);
        int unsigned w;
        int top, mid, bot, t1, m1, b1, t2, m2, b2, ga, gb;
        grad_word_t word;
        w = eff_width(line_width_reg);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // width shrunk under a running row
        if (col_pos >= w)
            step_row();
        top = upper_line[col_pos];
        mid = lower_line[col_pos];
        bot = pix;
        t1 = win_regs[0]; m1 = win_regs[1]; b1 = win_regs[2];
        t2 = win_regs[3]; m2 = win_regs[4]; b2 = win_regs[5];
        if (row_pos >= 2 && col_pos >= 2)
        begin
            ga = (t2 + 2 * t1 + top) - (b2 + 2 * b1 + bot);
            gb = (t2 + 2 * m2 + b2) - (top + 2 * mid + bot);
            word.grad_a     = ga[GRAD_BITS-1:0];
            word.grad_b     = gb[GRAD_BITS-1:0];
            word.centre_row = ROW_BITS'(row_pos - 1);
            word.centre_col = COL_BITS'(col_pos - 1);
            expected_grads = {expected_grads, word};
        end
        win_regs[3] = t1[PIXEL_BITS-1:0];
        win_regs[4] = m1[PIXEL_BITS-1:0];
        win_regs[5] = b1[PIXEL_BITS-1:0];
        win_regs[0] = top[PIXEL_BITS-1:0];
        win_regs[1] = mid[PIXEL_BITS-1:0];
        win_regs[2] = pix;
        upper_line[col_pos] = mid[PIXEL_BITS-1:0];
        lower_line[col_pos] = pix;
        col_pos++;
        if (col_pos >= w)
            step_row();
    endfunction

    // pixel driver, prediction taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel       <= '0;
            frame_start <= 1'b0;
            in_hold     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_gradients(pixel, frame_start);
                words_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && in_hold >= pixel_queue[0].gap)
                begin
                    in_valid    <= 1'b1;
                    pixel       <= pixel_queue[0].pixel;
                    frame_start <= pixel_queue[0].frame_start;
                    in_hold     <= 0;
                    void'(pixel_queue.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pixel_queue.size() != 0)
                        in_hold <= in_hold + 1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        grad_word_t want;
        int gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_grads.size() == 0)
            begin
                $error("result word with none expected: grad_a %0d grad_b %0d row %0d col %0d",
                       grad_a, grad_b, centre_row, centre_col);
                error_count++;
            end
            else
            begin
                want = expected_grads.pop_front();
                if (grad_a !== want.grad_a)
                begin
                    $error("grad_a: expected %0d, actual %0d", want.grad_a, grad_a);
                    error_count++;
                end
                if (grad_b !== want.grad_b)
                begin
                    $error("grad_b: expected %0d, actual %0d", want.grad_b, grad_b);
                    error_count++;
                end
                if (centre_row !== want.centre_row)
                begin
                    $error("centre_row: expected %0d, actual %0d", want.centre_row, centre_row);
                    error_count++;
                end
                if (centre_col !== want.centre_col)
                begin
                    $error("centre_col: expected %0d, actual %0d", want.centre_col, centre_col);
                    error_count++;
                end
            end
            out_count++;
            if (out_count % MODE_SPAN == 0)
                out_mode = draw_mode();
            gap = draw_gap(out_mode);
            if (gap == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                out_hold  <= gap;
            end
        end
        else if (!out_ready)
        begin
            if (out_hold <= 1)
                out_ready <= 1'b1;
            else
                out_hold <= out_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(logic [PIXEL_BITS-1:0] pix, logic fs);
        pixel_word_t word;
        if (words_queued % MODE_SPAN == 0)
            in_mode = draw_mode();
        word.pixel       = pix;
        word.frame_start = fs;
        word.gap         = draw_gap(in_mode);
        pixel_queue = {pixel_queue, word};
        words_queued++;
    endtask

    task automatic push_row3(logic [PIXEL_BITS-1:0] p0, logic [PIXEL_BITS-1:0] p1,
                             logic [PIXEL_BITS-1:0] p2, logic fs);
        push_pixel(p0, fs);
        push_pixel(p1, 1'b0);
        push_pixel(p2, 1'b0);
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_grads.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic set_line_width(logic [LINE_W_BITS-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        line_width_reg = value;
    endtask

    initial
    begin
        int unsigned w;
        int sel, frames, run, rand_base;
        logic [LINE_W_BITS-1:0] new_width;
        logic fs;

        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win_regs[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset width, stores straight out of reset, no frame start; one row and a bit
        for (int i = 0; i < 640 + 5; i++)
            push_pixel(rand_pixel(), 1'b0);

        // width shrinks mid-row: column wraps before the pixel is taken
        set_line_width(11'd3);
        push_row3(8'd17, 8'd200, 8'd99, 1'b0);

        // extreme gradients on small frames
        push_row3(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_row3(8'h00, 8'h00, 8'h00, 1'b0);
        push_row3(8'h00, 8'h00, 8'h00, 1'b0);
        push_row3(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_row3(8'hFF, 8'h00, 8'h00, 1'b1);
        push_row3(8'hFF, 8'h00, 8'h00, 1'b0);
        push_row3(8'hFF, 8'h00, 8'h00, 1'b0);
        push_row3(8'h00, 8'h00, 8'hFF, 1'b1);
        push_row3(8'h00, 8'h00, 8'hFF, 1'b0);
        push_row3(8'h00, 8'h00, 8'hFF, 1'b0);

        // widths below the minimum act as three
        for (int v = 0; v < 3; v++)
        begin
            set_line_width(LINE_W_BITS'(v));
            for (int i = 0; i < 10; i++)
                push_pixel(rand_pixel(), (v == 2 && i == 0));
        end

        // all ones acts as the widest row; the row reached shows once the width shrinks
        set_line_width(11'h7FF);
        push_pixel(rand_pixel(), 1'b1);
        for (int i = 1; i < MAX_WIDTH + 4; i++)
            push_pixel(rand_pixel(), 1'b0);
        set_line_width(11'd3);
        push_row3(rand_pixel(), rand_pixel(), rand_pixel(), 1'b0);

        rand_base = words_queued;
        while (words_queued < rand_base + RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 15);
            if (sel == 0)
                new_width = LINE_W_BITS'($urandom_range(0, 2));
            else if (sel == 1)
                new_width = LINE_W_BITS'($urandom_range(1025, 2047));
            else if (sel == 2)
                new_width = LINE_W_BITS'($urandom_range(25, 1024));
            else
                new_width = LINE_W_BITS'($urandom_range(3, 24));
            set_line_width(new_width);
            w = eff_width(new_width);
            if (w > 24)
            begin
                // wide rows: a short run only
                run = $urandom_range(1, 120);
                for (int i = 0; i < run; i++)
                    push_pixel(rand_pixel(), ($urandom_range(0, 63) == 0));
            end
            else
            begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++)
                begin
                    run = $urandom_range(3, 6) * w + $urandom_range(0, w);
                    for (int i = 0; i < run; i++)
                    begin
                        // mostly clean frames, sometimes a run continues or restarts early
                        fs = (i == 0 && !(f == 0 && $urandom_range(0, 7) == 0))
                             || ($urandom_range(0, 63) == 0);
                        push_pixel(rand_pixel(), fs);
                    end
                end
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
